// ===== rtl/core/imgconv3_pkg.sv =====
// Shared types and constants for the 3x3 image convolution block.
// No dependencies; imported by the top level and its checker.
package imgconv3_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int COEF_W     = 16;
    localparam int KSIZE      = 3;
    localparam int KROW_W     = COEF_W * KSIZE;
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = PIX_W + 1 + COEF_W;   // unsigned pixel times signed coef
    localparam int ROW_SUM_W  = PROD_W + 2;
    localparam int SUM_W      = ROW_SUM_W + 2;
    localparam int PIX_MAX    = 255;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_KROW_TOP     = 3'd2,
        REG_KROW_MIDDLE  = 3'd3,
        REG_KROW_BOTTOM  = 3'd4
    } t_cfg_idx;

    // per-pixel tag carried down the pipeline
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
        logic               has_int;
        logic               has_brd;
    } t_tag;

    typedef struct packed {
        logic               last;
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_result;

endpackage

// ===== rtl/core/image_convolution_3x3_top.sv =====
// 3x3 convolution over a raster pixel stream: line stores, window, MAC, output queue.
// Steps from input beat to result in the output queue: pixel read,
// window update, multiply, row sums, final sum and clamp. Throughput: one
// pixel per cycle; the input stalls only while fewer than two of the 16
// output queue slots are unclaimed by queued results or pixels in flight.
// Reset (i_rst_n, synchronous, active low) clears counters, window, pipeline valids and
// queue, and loads default config registers; line stores keep their contents.
module image_convolution_3x3_top #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // pixel input
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [imgconv3_pkg::PIX_W-1:0]        i_s_axis_tdata,  // [7:0] pixel_in
    // result output
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [9:0] out_column, [19:10] out_row, [27:20] out_value, [31:28] zero
    output logic [imgconv3_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,  // last_of_run
    // config write
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [imgconv3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [imgconv3_pkg::KROW_W-1:0]       i_cfg_data
);
    import imgconv3_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WDW = (XW + 1 > CFG_DIM_W) ? XW + 1 : CFG_DIM_W;
    localparam int HDW = (YW + 1 > CFG_DIM_W) ? YW + 1 : CFG_DIM_W;
    localparam int NWIN = KSIZE * KSIZE;
    localparam int PEND_W = FIFO_AW + 1;
    localparam logic signed [SUM_W-1:0] SAT_LVL = SUM_W'(PIX_MAX) <<< COEF_FRAC_BITS;

    // ---------------- config registers ----------------
    logic [CFG_DIM_W-1:0] r_cfg_width, r_cfg_height;
    logic [KROW_W-1:0]    r_krow [KSIZE];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_DIM_W'(1024);
            r_cfg_height <= CFG_DIM_W'(1024);
            r_krow[0]    <= '0;
            r_krow[1]    <= KROW_W'(48'h0000_0100_0000);
            r_krow[2]    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[CFG_DIM_W-1:0];
                REG_KROW_TOP:     r_krow[0]    <= i_cfg_data;
                REG_KROW_MIDDLE:  r_krow[1]    <= i_cfg_data;
                REG_KROW_BOTTOM:  r_krow[2]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [WDW-1:0] w_eff;
    logic [HDW-1:0] h_eff;

    always_comb begin
        if (r_cfg_width == '0)                           w_eff = WDW'(1);
        else if (WDW'(r_cfg_width) > WDW'(MAX_WIDTH))    w_eff = WDW'(MAX_WIDTH);
        else                                             w_eff = WDW'(r_cfg_width);
        if (r_cfg_height == '0)                          h_eff = HDW'(1);
        else if (HDW'(r_cfg_height) > HDW'(MAX_HEIGHT))  h_eff = HDW'(MAX_HEIGHT);
        else                                             h_eff = HDW'(r_cfg_height);
    end

    // ---------------- stage 0: coordinates, line store read ----------------
    logic [XW-1:0] r_col, n_col, cur_x;
    logic [YW-1:0] r_row, n_row, cur_y;
    logic [XW:0]   x_inc;
    logic [YW:0]   y_pre, y_inc;
    logic          col_wrap, has_int, has_brd;
    logic [1:0]    nres;
    logic          s_acc;
    logic [PEND_W-1:0] r_pend;
    t_tag          tag0;

    assign o_s_axis_tready = (r_pend <= PEND_W'(FIFO_DEPTH - 2));
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        // a width change while idle can leave the column past the row end
        col_wrap = WDW'(r_col) >= w_eff;
        cur_x    = col_wrap ? '0 : r_col;
        y_pre    = col_wrap ? (YW+1)'(r_row) + (YW+1)'(1) : (YW+1)'(r_row);
        cur_y    = (HDW'(y_pre) >= h_eff) ? '0 : y_pre[YW-1:0];
        x_inc    = (XW+1)'(cur_x) + (XW+1)'(1);
        y_inc    = (YW+1)'(cur_y) + (YW+1)'(1);
        if (WDW'(x_inc) >= w_eff) begin
            n_col = '0;
            n_row = (HDW'(y_inc) >= h_eff) ? '0 : y_inc[YW-1:0];
        end else begin
            n_col = x_inc[XW-1:0];
            n_row = cur_y;
        end
        has_int = (cur_x >= XW'(2)) && (cur_y >= YW'(2));
        has_brd = (cur_x == '0) || (cur_y == '0) ||
                  (WDW'(cur_x) == w_eff - WDW'(1)) || (HDW'(cur_y) == h_eff - HDW'(1));
        nres    = {1'b0, has_int} + {1'b0, has_brd};
        tag0.col     = COORD_W'(cur_x);
        tag0.row     = COORD_W'(cur_y);
        tag0.pix     = i_s_axis_tdata;
        tag0.has_int = has_int;
        tag0.has_brd = has_brd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1: line store write-back, window shift ----------------
    logic [PIX_W-1:0] r_line_a [MAX_WIDTH];
    logic [PIX_W-1:0] r_line_b [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_a, r_rd_b;
    logic             r1_vld, r1_fwd;
    logic [XW-1:0]    r1_x;
    logic [PIX_W-1:0] r1_fa, r1_fb;
    t_tag             r1_tag;
    logic [PIX_W-1:0] eff_a, eff_b;

    // same column on back-to-back beats: the read missed the write in flight
    assign eff_a = r1_fwd ? r1_fa : r_rd_a;
    assign eff_b = r1_fwd ? r1_fb : r_rd_b;

    always_ff @(posedge i_clk) begin
        if (s_acc) r_rd_a <= r_line_a[cur_x];
        if (r1_vld) r_line_a[r1_x] <= r1_tag.pix;
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) r_rd_b <= r_line_b[cur_x];
        if (r1_vld) r_line_b[r1_x] <= eff_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r1_fwd <= 1'b0;
        end else begin
            r1_vld <= s_acc;
            if (s_acc) r1_fwd <= r1_vld && (r1_x == cur_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r1_x   <= cur_x;
            r1_tag <= tag0;
            r1_fa  <= r1_tag.pix;
            r1_fb  <= eff_a;
        end
    end

    logic [PIX_W-1:0] r_win [NWIN];
    logic             r2_vld;
    t_tag             r2_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NWIN; i++) r_win[i] <= '0;
        end else if (r1_vld) begin
            for (int r = 0; r < KSIZE; r++) begin
                r_win[r*KSIZE]     <= r_win[r*KSIZE + 1];
                r_win[r*KSIZE + 1] <= r_win[r*KSIZE + 2];
            end
            r_win[2] <= eff_b;
            r_win[5] <= eff_a;
            r_win[8] <= r1_tag.pix;
        end
    end

    // ---------------- stage 2: nine products ----------------
    logic signed [PROD_W-1:0] n_prod [NWIN];
    logic signed [PROD_W-1:0] r3_prod [NWIN];
    logic                     r3_vld;
    t_tag                     r3_tag;

    // slot c of a kernel row meets the window column 2-c (mirrored kernel)
    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
                n_prod[r*KSIZE + c] =
                    $signed({1'b0, r_win[r*KSIZE + (KSIZE - 1 - c)]}) *
                    $signed(r_krow[r][c*COEF_W +: COEF_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NWIN; i++) r3_prod[i] <= n_prod[i];
        r3_tag <= r2_tag;
        if (r1_vld) r2_tag <= r1_tag;
    end

    // ---------------- stage 3: row sums ----------------
    logic signed [ROW_SUM_W-1:0] r4_row [KSIZE];
    logic                        r4_vld;
    t_tag                        r4_tag;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < KSIZE; r++) begin
            r4_row[r] <= ROW_SUM_W'(r3_prod[r*KSIZE]) + ROW_SUM_W'(r3_prod[r*KSIZE + 1])
                       + ROW_SUM_W'(r3_prod[r*KSIZE + 2]);
        end
        r4_tag <= r3_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // ---------------- stage 4: final sum, clamp, queue write ----------------
    logic signed [SUM_W-1:0] n_sum, n_shift;
    logic [PIX_W-1:0]        n_value;
    t_result                 e0, e1;
    logic [1:0]              n_wr;

    always_comb begin
        n_sum   = SUM_W'(r4_row[0]) + SUM_W'(r4_row[1]) + SUM_W'(r4_row[2]);
        n_shift = n_sum >>> COEF_FRAC_BITS;
        if (n_sum < 0)             n_value = '0;
        else if (n_sum >= SAT_LVL) n_value = PIX_W'(PIX_MAX);
        else                       n_value = n_shift[PIX_W-1:0];

        e1.col   = r4_tag.col;
        e1.row   = r4_tag.row;
        e1.value = r4_tag.pix;
        e1.last  = 1'b1;
        if (r4_tag.has_int) begin
            e0.col   = r4_tag.col - COORD_W'(1);
            e0.row   = r4_tag.row - COORD_W'(1);
            e0.value = n_value;
            e0.last  = !r4_tag.has_brd;
        end else begin
            e0 = e1;
        end
        n_wr = r4_vld ? ({1'b0, r4_tag.has_int} + {1'b0, r4_tag.has_brd}) : 2'd0;
    end

    // ---------------- output queue ----------------
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [PEND_W-1:0]    r_cnt;
    logic                 pop;
    t_result              head;

    assign head            = r_fifo[r_rd];
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = OUT_TDATA_W'({head.value, head.row, head.col});
    assign o_m_axis_tlast  = head.last;

    always_ff @(posedge i_clk) begin
        if (n_wr != 2'd0) r_fifo[r_wr] <= e0;
        if (n_wr == 2'd2) r_fifo[r_wr + FIFO_AW'(1)] <= e1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
            r_pend <= '0;
        end else begin
            r_wr   <= r_wr + FIFO_AW'(n_wr);
            if (pop) r_rd <= r_rd + FIFO_AW'(1);
            r_cnt  <= r_cnt + PEND_W'(n_wr) - PEND_W'(pop);
            // slots held by queued results plus results of pixels still in the pipe
            r_pend <= r_pend + (s_acc ? PEND_W'(nres) : '0) - PEND_W'(pop);
        end
    end

endmodule

// ===== rtl/core/imgconv3_chk.sv =====
// Port-level checker for image_convolution_3x3_top, bound to the top level.
// Depends on imgconv3_pkg for port widths.
module imgconv3_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic [imgconv3_pkg::PIX_W-1:0]        i_s_axis_tdata,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [imgconv3_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                                  o_m_axis_tlast,
    input logic                                  i_cfg_valid,
    input logic                                  o_cfg_ready,
    input logic [imgconv3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [imgconv3_pkg::KROW_W-1:0]       i_cfg_data
);
    import imgconv3_pkg::*;

    // input beat to first edge at which the queued result is visible
    localparam int PIPE_LAT = 5;

    logic in_beat;
    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output beat changed while stalled");

    // reset empties the output queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // an empty queue refills only from a pixel taken one pipeline latency ago
    a_fill_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(in_beat, PIPE_LAT))
        else $error("result without matching input beat");

    // output value field padding stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_TDATA_W-1:28] == '0))
        else $error("tdata padding not zero");

endmodule

bind image_convolution_3x3_top imgconv3_chk u_imgconv3_chk (.*);
